/* rtl/euler_to_rotation_matrix_core_assert.svh */
// assertion macros for the euler to rotation matrix core
// no dependencies
`ifndef EULER_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
`define E2R_ASSERT_IMPL(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("e2r check");
`define E2R_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("e2r check");
`endif

/* rtl/e2r_pkg.sv */
// package for the euler to rotation matrix core: word types, constants, atan table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package e2r_pkg;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int IN_W           = 16;
    localparam int OUT_W          = 16;
    localparam int WORK_FRAC      = 30;
    localparam int CORDIC_STEPS   = 30;
    localparam int ZW             = 34;
    localparam int XW             = 34;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [IN_W-1:0] roll_angle;
        logic signed [IN_W-1:0] pitch_angle;
        logic signed [IN_W-1:0] yaw_angle;
    } t_in_word;

    typedef struct packed {
        logic signed [OUT_W-1:0] row0_col0;
        logic signed [OUT_W-1:0] row0_col1;
        logic signed [OUT_W-1:0] row0_col2;
        logic signed [OUT_W-1:0] row1_col0;
        logic signed [OUT_W-1:0] row1_col1;
        logic signed [OUT_W-1:0] row1_col2;
        logic signed [OUT_W-1:0] row2_col0;
        logic signed [OUT_W-1:0] row2_col1;
        logic signed [OUT_W-1:0] row2_col2;
    } t_out_word;

    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic [31:0] v;
        begin
            unique case (i)
                0: v = 32'h20000000;   1: v = 32'h12E4051D;
                2: v = 32'h09FB385B;   3: v = 32'h051111D4;
                4: v = 32'h028B0D43;   5: v = 32'h0145D7E1;
                6: v = 32'h00A2F61E;   7: v = 32'h00517C55;
                8: v = 32'h0028BE53;   9: v = 32'h00145F2E;
                10: v = 32'h000A2F98;  11: v = 32'h000517CC;
                12: v = 32'h00028BE6;  13: v = 32'h000145F3;
                14: v = 32'h0000A2F9;  15: v = 32'h0000517C;
                16: v = 32'h000028BE;  17: v = 32'h0000145F;
                18: v = 32'h00000A2F;  19: v = 32'h00000517;
                20: v = 32'h0000028B;  21: v = 32'h00000145;
                22: v = 32'h000000A2;  23: v = 32'h00000051;
                24: v = 32'h00000028;  25: v = 32'h00000014;
                26: v = 32'h0000000A;  27: v = 32'h00000005;
                28: v = 32'h00000002;  29: v = 32'h00000001;
                default: v = 32'h0;
            endcase
            atan_val = $signed({2'b00, v});
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/e2r_cordic_stage.sv */
// one registered cordic rotation step for three angles side by side
// depends on e2r_pkg
`timescale 1ns / 1ps
`default_nettype none
module e2r_cordic_stage #(
    parameter int STEP = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [3*e2r_pkg::XW-1:0] i_x,
    input  wire logic signed [3*e2r_pkg::XW-1:0] i_y,
    input  wire logic signed [3*e2r_pkg::ZW-1:0] i_z,
    output logic signed [3*e2r_pkg::XW-1:0]      o_x,
    output logic signed [3*e2r_pkg::XW-1:0]      o_y,
    output logic signed [3*e2r_pkg::ZW-1:0]      o_z
);
    import e2r_pkg::*;
    logic signed [3*XW-1:0] n_x, n_y;
    logic signed [3*ZW-1:0] n_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [XW-1:0] x, y, xs, ys;
            logic signed [ZW-1:0] z;
            x = i_x[k*XW +: XW];
            y = i_y[k*XW +: XW];
            z = i_z[k*ZW +: ZW];
            xs = x >>> STEP;
            ys = y >>> STEP;
            if (!z[ZW-1]) begin
                n_x[k*XW +: XW] = x - ys;
                n_y[k*XW +: XW] = y + xs;
                n_z[k*ZW +: ZW] = z - atan_val(STEP);
            end else begin
                n_x[k*XW +: XW] = x + ys;
                n_y[k*XW +: XW] = y - xs;
                n_z[k*ZW +: ZW] = z + atan_val(STEP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= n_x;
            o_y <= n_y;
            o_z <= n_z;
        end
    end
endmodule
`default_nettype wire

/* rtl/euler_to_rotation_matrix_core.sv */
// euler zyx angles to rotation matrix, pipelined cordic and product stages
// depends on e2r_pkg, e2r_cordic_stage and the assertion header
//
// channel | dir | handshake         | word
// in      | in  | i_valid / o_stall | t_in_word, three binary angles
// out     | out | o_valid / i_stall | t_out_word, nine Q2.14 entries
//
// one word per cycle while the output is not stalled; stages: 1 input, 30 cordic, 1 round, 4 product
// the thirty cordic steps set the latency
// synchronous active-low reset clears the valid bits only
// a stall on the output freezes the whole pipeline; o_stall follows i_stall
// when the output holds a word
`timescale 1ns / 1ps
`default_nettype none
`include "euler_to_rotation_matrix_core_assert.svh"
module euler_to_rotation_matrix_core #(
    parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = e2r_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire e2r_pkg::t_in_word  i_word,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output e2r_pkg::t_out_word      o_word
);
    import e2r_pkg::*;
    localparam int FW    = FRAC_BITS + 2;
    localparam int PW    = 2 * FW;
    localparam int RSH   = WORK_FRAC - FRAC_BITS;
    localparam int DEPTH = CORDIC_STEPS + 6;
    localparam logic signed [FW-1:0] ONE  = FW'(1) <<< FRAC_BITS;
    localparam logic signed [FW-1:0] MONE = -ONE;

    logic             en;
    logic [DEPTH-1:0] r_vld;
    assign en      = !(r_vld[DEPTH-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    function automatic logic signed [FW-1:0] sat(input logic signed [PW:0] v);
        if (v > PW'(ONE)) sat = ONE;
        else if (v < -$signed((PW+1)'(ONE))) sat = MONE;
        else sat = v[FW-1:0];
    endfunction

    function automatic logic signed [PW:0] fmul(input logic signed [FW-1:0] a,
                                               input logic signed [FW-1:0] b);
        logic signed [PW:0] p;
        p = (PW+1)'(a) * (PW+1)'(b) + ((PW+1)'(1) <<< (FRAC_BITS - 1));
        fmul = p >>> FRAC_BITS;
    endfunction

    // stage 0: quadrant fold
    logic signed [3*XW-1:0] r_x0, r_y0;
    logic signed [3*ZW-1:0] r_z0;
    logic [2:0] n_flip0;
    logic signed [3*ZW-1:0] n_z0;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [31:0] raw;
            logic [31:0] a;
            raw = (k == 0) ? 32'({i_word.roll_angle}) :
                  (k == 1) ? 32'({i_word.pitch_angle}) : 32'({i_word.yaw_angle});
            a = 32'(raw[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
            n_flip0[k] = a[31] ^ a[30];
            if (n_flip0[k]) a = a + 32'h80000000;
            n_z0[k*ZW +: ZW] = $signed({{(ZW-32){a[31]}}, a});
        end
    end
    logic [2:0] r_flip [CORDIC_STEPS+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z0 <= n_z0;
            r_x0 <= {3{CORDIC_GAIN}};
            r_y0 <= '0;
            r_flip[0] <= n_flip0;
            for (int s = 1; s <= CORDIC_STEPS; s++) r_flip[s] <= r_flip[s-1];
        end
    end

    logic signed [3*XW-1:0] cx [CORDIC_STEPS+1];
    logic signed [3*XW-1:0] cy [CORDIC_STEPS+1];
    logic signed [3*ZW-1:0] cz [CORDIC_STEPS+1];
    assign cx[0] = r_x0;
    assign cy[0] = r_y0;
    assign cz[0] = r_z0;
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        e2r_cordic_stage #(.STEP(g)) u_stage (
            .i_clk(i_clk), .i_en(en),
            .i_x(cx[g]), .i_y(cy[g]), .i_z(cz[g]),
            .o_x(cx[g+1]), .o_y(cy[g+1]), .o_z(cz[g+1])
        );
    end

    // round to output precision
    logic signed [FW-1:0] r_s [3];
    logic signed [FW-1:0] r_c [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [XW:0] x, y;
                logic signed [XW:0] rx, ry;
                x = (XW+1)'($signed(cx[CORDIC_STEPS][k*XW +: XW]));
                y = (XW+1)'($signed(cy[CORDIC_STEPS][k*XW +: XW]));
                if (r_flip[CORDIC_STEPS][k]) begin
                    x = -x;
                    y = -y;
                end
                rx = (x + ((XW+1)'(1) <<< (RSH - 1))) >>> RSH;
                ry = (y + ((XW+1)'(1) <<< (RSH - 1))) >>> RSH;
                r_c[k] <= (rx > (XW+1)'(ONE)) ? ONE :
                          (rx < -$signed((XW+1)'(ONE))) ? MONE : rx[FW-1:0];
                r_s[k] <= (ry > (XW+1)'(ONE)) ? ONE :
                          (ry < -$signed((XW+1)'(ONE))) ? MONE : ry[FW-1:0];
            end
        end
    end

    // product stage a: sr*sp, cr*sp, and keep trig values
    logic signed [FW-1:0] r_a_srsp, r_a_crsp, r_a_sr, r_a_cr, r_a_sp, r_a_cp;
    logic signed [FW-1:0] r_a_sy, r_a_cy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_srsp <= FW'(fmul(r_s[0], r_s[1]));
            r_a_crsp <= FW'(fmul(r_c[0], r_s[1]));
            r_a_sr <= r_s[0]; r_a_cr <= r_c[0];
            r_a_sp <= r_s[1]; r_a_cp <= r_c[1];
            r_a_sy <= r_s[2]; r_a_cy <= r_c[2];
        end
    end

    // product stage b: all two-term products
    logic signed [PW:0] r_b [12];
    logic signed [FW-1:0] r_b_sp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b[0]  <= fmul(r_a_cp, r_a_cy);
            r_b[1]  <= fmul(r_a_srsp, r_a_cy);
            r_b[2]  <= fmul(r_a_cr, r_a_sy);
            r_b[3]  <= fmul(r_a_crsp, r_a_cy);
            r_b[4]  <= fmul(r_a_sr, r_a_sy);
            r_b[5]  <= fmul(r_a_cp, r_a_sy);
            r_b[6]  <= fmul(r_a_srsp, r_a_sy);
            r_b[7]  <= fmul(r_a_cr, r_a_cy);
            r_b[8]  <= fmul(r_a_crsp, r_a_sy);
            r_b[9]  <= fmul(r_a_sr, r_a_cy);
            r_b[10] <= fmul(r_a_sr, r_a_cp);
            r_b[11] <= fmul(r_a_cr, r_a_cp);
            r_b_sp  <= r_a_sp;
        end
    end

    // stage c: sums
    logic signed [PW:0] r_m [9];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m[0] <= r_b[0];
            r_m[1] <= r_b[1] - r_b[2];
            r_m[2] <= r_b[3] + r_b[4];
            r_m[3] <= r_b[5];
            r_m[4] <= r_b[6] + r_b[7];
            r_m[5] <= r_b[8] - r_b[9];
            r_m[6] <= -(PW+1)'(r_b_sp);
            r_m[7] <= r_b[10];
            r_m[8] <= r_b[11];
        end
    end

    // stage d: saturate into output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_word.row0_col0 <= OUT_W'(sat(r_m[0]));
            o_word.row0_col1 <= OUT_W'(sat(r_m[1]));
            o_word.row0_col2 <= OUT_W'(sat(r_m[2]));
            o_word.row1_col0 <= OUT_W'(sat(r_m[3]));
            o_word.row1_col1 <= OUT_W'(sat(r_m[4]));
            o_word.row1_col2 <= OUT_W'(sat(r_m[5]));
            o_word.row2_col0 <= OUT_W'(sat(r_m[6]));
            o_word.row2_col1 <= OUT_W'(sat(r_m[7]));
            o_word.row2_col2 <= OUT_W'(sat(r_m[8]));
        end
    end

    `E2R_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, !o_stall || o_valid)
    `E2R_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_word))
    `E2R_ASSERT_NEXT(a_vld_moves, i_clk, i_rst_n, !o_stall && i_valid, r_vld[0])
endmodule
`default_nettype wire

/* dv/euler_to_rotation_matrix_core_test.sv */
// testbench for the euler to rotation matrix core: directed and random angle words
// depends on e2r_pkg and euler_to_rotation_matrix_core; checks every matrix word in order
`timescale 1ns / 1ps
module euler_to_rotation_matrix_core_test;
    import e2r_pkg::*;

    localparam int FB = 14;
    localparam longint ONE = 64'sd1 << FB;
    localparam int LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in_word i_word = '0;
    logic o_stall, o_valid;
    t_out_word o_word;

    int send_idle = 0;
    int recv_idle = 0;
    int errors = 0;
    int cycles = 0;
    t_out_word matrix_q[$];

    euler_to_rotation_matrix_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_word(i_word), .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        if (s == 0) return v;
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_sh(a * b, FB);
    endfunction

    function automatic longint arctan_step(int i);
        longint t[30] = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53,
            64'h00145F2E, 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3,
            64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F,
            64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051,
            64'h00000028, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002,
            64'h00000001};
        return t[i];
    endfunction

    function automatic void sine_cosine(input logic [15:0] ang, output longint s,
                                        output longint c);
        logic [31:0] a;
        logic [1:0] quad;
        logic flip;
        longint z, x, y, nx;
        a = {ang, 16'h0};
        quad = a[31:30];
        flip = (quad == 2'd1) || (quad == 2'd2);
        if (flip) a = a + 32'h80000000;
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = x - floor_sh(y, i);
                y = y + floor_sh(x, i);
                z -= arctan_step(i);
            end else begin
                nx = x + floor_sh(y, i);
                y = y - floor_sh(x, i);
                z += arctan_step(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp_one(round_sh(x, 30 - FB));
        s = clamp_one(round_sh(y, 30 - FB));
    endfunction

    function automatic t_out_word rotation_of(t_in_word w);
        longint sr, cr, sp, cp, sy, cy, srsp, crsp;
        t_out_word r;
        sine_cosine(w.roll_angle, sr, cr);
        sine_cosine(w.pitch_angle, sp, cp);
        sine_cosine(w.yaw_angle, sy, cy);
        srsp = qmul(sr, sp);
        crsp = qmul(cr, sp);
        r.row0_col0 = 16'(clamp_one(qmul(cp, cy)));
        r.row0_col1 = 16'(clamp_one(qmul(srsp, cy) - qmul(cr, sy)));
        r.row0_col2 = 16'(clamp_one(qmul(crsp, cy) + qmul(sr, sy)));
        r.row1_col0 = 16'(clamp_one(qmul(cp, sy)));
        r.row1_col1 = 16'(clamp_one(qmul(srsp, sy) + qmul(cr, cy)));
        r.row1_col2 = 16'(clamp_one(qmul(crsp, sy) - qmul(sr, cy)));
        r.row2_col0 = 16'(clamp_one(-sp));
        r.row2_col1 = 16'(clamp_one(qmul(sr, cp)));
        r.row2_col2 = 16'(clamp_one(qmul(cr, cp)));
        return r;
    endfunction

    // sends one word, with random idle cycles before it
    task automatic send_angles(input logic [15:0] r, input logic [15:0] p, input logic [15:0] y);
        t_in_word w;
        w.roll_angle = r;
        w.pitch_angle = p;
        w.yaw_angle = y;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word <= w;
        matrix_q.push_back(rotation_of(w));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n) i_stall <= ($urandom_range(99) < recv_idle);
        if (o_valid && !i_stall) begin
            if (matrix_q.size() == 0) begin
                $display("%0t unexpected word %h", $time, o_word);
                errors++;
            end else begin
                t_out_word e;
                e = matrix_q.pop_front();
                if (e != o_word) begin
                    $display("%0t expected %h actual %h", $time, e, o_word);
                    errors++;
                end
            end
        end
    end

    task automatic test_extremes;
        logic [15:0] v[8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                              16'h4000, 16'hC000, 16'h2000, 16'h0001};
        for (int i = 0; i < 8; i++) send_angles(v[i], v[(i + 3) % 8], v[(i + 5) % 8]);
        send_angles(16'h4000, 16'h4000, 16'h4000);
        send_angles(16'hC000, 16'hC000, 16'hC000);
        send_angles(16'h3FFF, 16'h4001, 16'hBFFF);
        send_angles(16'h5555, 16'hAAAA, 16'h8001);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_quadrant_edges(input int n);
        for (int i = 0; i < n; i++)
            send_angles(16'($urandom_range(3) << 14) + 16'($signed($urandom_range(8)) - 4),
                        16'($urandom_range(3) << 14) + 16'($urandom_range(3)),
                        16'($urandom));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle = 28;
        recv_idle = 54;
        test_extremes();
        test_random(230);
        send_idle = 54;
        recv_idle = 28;
        test_quadrant_edges(60);
        test_random(170);
        send_idle = 0;
        recv_idle = 0;
        test_random(200);
        i_valid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
